// File: design/gsem_pkg.sv
// ----------------------------------------------------------------------------
// gsem_pkg: shared types and constants for the gamepad to servo/ESC mapper
// Payload structs, code enums, reset values, rumble patterns and the divider
// length used by both the controller and the datapath.
// ----------------------------------------------------------------------------
package gsem_pkg;

   // event kinds
   typedef enum logic [1:0] {
      KIND_REPORT     = 2'd0,
      KIND_TICK       = 2'd1,
      KIND_CONNECT    = 2'd2,
      KIND_DISCONNECT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_ECO    = 2'd0,
      MODE_NORMAL = 2'd1,
      MODE_SPORT  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      LED_OFF   = 2'd0,
      LED_GREEN = 2'd1,
      LED_BLUE  = 2'd2,
      LED_RED   = 2'd3
   } led_type;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_MIN    = 3'd0,
      CSR_ANGLE_MAX    = 3'd1,
      CSR_ANGLE_CENTER = 3'd2,
      CSR_DEAD_ZONE    = 3'd3,
      CSR_HOLD_MS      = 3'd4,
      CSR_MOTOR_INV    = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] stick_x;
      logic [7:0]         throttle_trigger;
      logic [7:0]         brake_trigger;
      logic               left_shoulder;
      logic               right_shoulder;
   } req_type;

   typedef struct packed {
      logic [7:0] servo_angle;
      logic [7:0] motor_pwm;
      logic [1:0] drive_mode;
      logic       pad_connected;
      logic       rumble_valid;
      logic [7:0] rumble_low_motor;
      logic [7:0] rumble_high_motor;
      logic [1:0] led_color;
   } rsp_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;
      logic mul;
      logic step;
      logic commit;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_MUL  = 2'd1,
      ST_DIV  = 2'd2,
      ST_DONE = 2'd3
   } state_type;

   // dividend is |stick offset| * |slope| <= 32768 * 255 < 2**23
   localparam int DIV_BITS = 23;
   localparam int CNT_W    = $clog2(DIV_BITS);

   // register reset values
   localparam logic [7:0]  ANGLE_MIN_RST    = 8'd45;
   localparam logic [7:0]  ANGLE_MAX_RST    = 8'd115;
   localparam logic [7:0]  ANGLE_CENTER_RST = 8'd85;
   localparam logic [14:0] DEAD_ZONE_RST    = 15'd4000;
   localparam logic [15:0] HOLD_MS_RST      = 16'd2000;

   localparam logic [7:0]  NEUTRAL    = 8'd90;
   localparam logic [15:0] STICK_POS  = 16'd32767;
   localparam logic [15:0] STICK_NEG  = 16'd32768;
   localparam logic [15:0] HOLD_SAT   = 16'd65535;
   localparam logic [9:0]  RUMBLE_SAT = 10'd1023;

   localparam logic [9:0] RUMBLE_LEN_NORMAL = 10'd250;
   localparam logic [9:0] RUMBLE_LEN_SPORT  = 10'd500;
   localparam logic [9:0] RUMBLE_LEN_ECO    = 10'd150;
   localparam logic [7:0] RUMBLE_HI_NORMAL  = 8'd100;
   localparam logic [7:0] RUMBLE_HI_SPORT   = 8'd255;
   localparam logic [7:0] RUMBLE_LO_ECO     = 8'd50;

   // distance of the PWM endpoint from neutral, per mode (eco 30, normal 60, sport 90)
   function automatic logic [6:0] motor_span(input logic [1:0] mode);
      logic [6:0] span;
      case (mode)
         MODE_NORMAL: span = 7'd60;
         MODE_SPORT:  span = 7'd90;
         default:     span = 7'd30;
      endcase
      return span;
   endfunction

endpackage

// File: design/gsem_ctrl.sv
// ----------------------------------------------------------------------------
// gsem_ctrl: sequencer for the mapper
// Accepts one event, steps the datapath through multiply and serial divide,
// then commits the result into the output register when it is free.
// ----------------------------------------------------------------------------
module gsem_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gsem_pkg::cmd_type cmd
);

   gsem_pkg::state_type state_ff, state_in;
   logic [gsem_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic div_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign div_last = (cnt_ff == gsem_pkg::CNT_W'(gsem_pkg::DIV_BITS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gsem_pkg::ST_IDLE: if (req_valid) state_in = gsem_pkg::ST_MUL;
         gsem_pkg::ST_MUL:  state_in = gsem_pkg::ST_DIV;
         gsem_pkg::ST_DIV:  if (div_last) state_in = gsem_pkg::ST_DONE;
         gsem_pkg::ST_DONE: if (out_free) state_in = gsem_pkg::ST_IDLE;
         default:           state_in = gsem_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_stall  = 1'b1;
      cnt_in     = cnt_ff;
      case (state_ff)
         gsem_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         gsem_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
            cnt_in  = '0;
         end
         gsem_pkg::ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
         end
         gsem_pkg::ST_DONE: begin
            cmd.commit = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsem_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: design/gsem_datapath.sv
// ----------------------------------------------------------------------------
// gsem_datapath: registers, stick scaling, motor mapping and event state
// Holds the configuration registers, the event state, a restoring divider
// for the stick slope and the result register.
// ----------------------------------------------------------------------------
module gsem_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  gsem_pkg::cmd_type                 cmd,
   input  gsem_pkg::req_type                 req_data,
   input  logic                              csr_we,
   input  logic [gsem_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gsem_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output gsem_pkg::rsp_type                 rsp_data
);

   // configuration
   logic [7:0]  amin_ff, amax_ff, acen_ff;
   logic [14:0] dz_ff;
   logic [15:0] hold_ms_ff;
   logic        inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amin_ff    <= gsem_pkg::ANGLE_MIN_RST;
         amax_ff    <= gsem_pkg::ANGLE_MAX_RST;
         acen_ff    <= gsem_pkg::ANGLE_CENTER_RST;
         dz_ff      <= gsem_pkg::DEAD_ZONE_RST;
         hold_ms_ff <= gsem_pkg::HOLD_MS_RST;
         inv_ff     <= 1'b0;
      end else if (csr_we) begin
         case (gsem_pkg::csr_idx_type'(csr_index))
            gsem_pkg::CSR_ANGLE_MIN:    amin_ff    <= csr_wdata[7:0];
            gsem_pkg::CSR_ANGLE_MAX:    amax_ff    <= csr_wdata[7:0];
            gsem_pkg::CSR_ANGLE_CENTER: acen_ff    <= csr_wdata[7:0];
            gsem_pkg::CSR_DEAD_ZONE:    dz_ff      <= csr_wdata[14:0];
            gsem_pkg::CSR_HOLD_MS:      hold_ms_ff <= csr_wdata;
            gsem_pkg::CSR_MOTOR_INV:    inv_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // event state
   logic [1:0] mode_ff, mode_in;
   logic [7:0] servo_ff, servo_in;
   logic [7:0] motor_ff, motor_in;
   logic       conn_ff, conn_in;
   logic       held_ff, held_in;
   logic       switched_ff, switched_in;
   logic [15:0] hold_ff, hold_in;
   logic       ract_ff, ract_in;
   logic [9:0] rel_ff, rel_in;
   logic [9:0] rlen_ff, rlen_in;
   logic [1:0] led_ff, led_in;

   // captured item
   gsem_pkg::req_type item_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;
   end

   // ---------------- multiply stage ----------------
   logic signed [16:0] x_s, dz_s, diff_r, diff_l;
   logic               right, left;
   logic [15:0]        num, den;
   logic signed [8:0]  slope_r, slope_l, slope;
   logic [8:0]         slope_abs;
   logic [23:0]        sprod;
   logic               m_gas;
   logic [7:0]         m_val;
   logic [14:0]        mprod;

   always_comb begin
      x_s     = {item_ff.stick_x[15], item_ff.stick_x};
      dz_s    = {2'b00, dz_ff};
      right   = x_s > dz_s;
      left    = x_s < -dz_s;
      diff_r  = x_s - dz_s;
      diff_l  = -x_s - dz_s;
      num     = right ? diff_r[15:0] : diff_l[15:0];
      slope_r = $signed({1'b0, amax_ff}) - $signed({1'b0, acen_ff});
      slope_l = $signed({1'b0, amin_ff}) - $signed({1'b0, acen_ff});
      slope   = right ? slope_r : slope_l;
      slope_abs = slope[8] ? 9'(-slope) : 9'(slope);
      den     = right ? (gsem_pkg::STICK_POS - {1'b0, dz_ff})
                      : (gsem_pkg::STICK_NEG - {1'b0, dz_ff});
      sprod   = {8'b0, num} * {16'b0, slope_abs[7:0]};

      // gas endpoint set unless inverted; brake alone takes the other set
      if (item_ff.throttle_trigger != 8'd0) begin
         m_gas = !inv_ff;
         m_val = item_ff.throttle_trigger;
      end else begin
         m_gas = inv_ff;
         m_val = item_ff.brake_trigger;
      end
      mprod = {7'b0, m_val} * {8'b0, gsem_pkg::motor_span(mode_ff)};
   end

   // ---------------- serial divider ----------------
   logic [gsem_pkg::DIV_BITS-1:0] dvd_ff;
   logic [15:0] dvs_ff, rem_ff;
   logic        neg_ff, right_ff, left_ff, mgas_ff;
   logic [14:0] mprod_ff;
   logic [16:0] trial, trial_sub;
   logic        ge;

   assign trial     = {rem_ff, dvd_ff[gsem_pkg::DIV_BITS-1]};
   assign ge        = trial >= {1'b0, dvs_ff};
   assign trial_sub = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         dvd_ff   <= sprod[gsem_pkg::DIV_BITS-1:0];
         dvs_ff   <= den;
         rem_ff   <= '0;
         neg_ff   <= slope[8];
         right_ff <= right;
         left_ff  <= left;
         mprod_ff <= mprod;
         mgas_ff  <= m_gas;
      end else if (cmd.step) begin
         // quotient bits shift into the dividend register
         rem_ff <= ge ? trial_sub[15:0] : trial[15:0];
         dvd_ff <= {dvd_ff[gsem_pkg::DIV_BITS-2:0], ge};
      end
   end

   // ---------------- commit ----------------
   logic [7:0]        quo;
   logic signed [9:0] ang, amin_s, amax_s;
   logic [7:0]        ang_clamped;
   logic [23:0]       m1, mscaled;
   logic [7:0]        mq, mot;
   logic              combo;
   logic [9:0]        rel_inc;
   logic [15:0]       hold_inc;
   logic              rv, started;
   logic [7:0]        rlo, rhi;

   always_comb begin
      quo    = dvd_ff[7:0];
      amin_s = $signed({2'b00, amin_ff});
      amax_s = $signed({2'b00, amax_ff});
      if (right_ff || left_ff)
         ang = $signed({2'b00, acen_ff}) + (neg_ff ? -$signed({2'b00, quo})
                                                   : $signed({2'b00, quo}));
      else
         ang = $signed({2'b00, acen_ff});
      if (ang < amin_s) ang_clamped = amin_ff;
      else if (ang > amax_s) ang_clamped = amax_ff;
      else ang_clamped = ang[7:0];

      // x / 255 == ((x + 1) * 257) >> 16 for x below 65535
      m1      = {9'b0, mprod_ff} + 24'd1;
      mscaled = (m1 << 8) + m1;
      mq      = mscaled[23:16];
      mot     = mgas_ff ? (gsem_pkg::NEUTRAL + mq) : (gsem_pkg::NEUTRAL - mq);

      combo = item_ff.left_shoulder && item_ff.right_shoulder;

      mode_in     = mode_ff;
      servo_in    = servo_ff;
      motor_in    = motor_ff;
      conn_in     = conn_ff;
      held_in     = held_ff;
      switched_in = switched_ff;
      hold_in     = hold_ff;
      ract_in     = ract_ff;
      rel_in      = rel_ff;
      rlen_in     = rlen_ff;
      led_in      = led_ff;
      rv          = 1'b0;
      started     = 1'b0;
      rlo         = 8'd0;
      rhi         = 8'd0;
      rel_inc     = (ract_ff && rel_ff < gsem_pkg::RUMBLE_SAT) ? rel_ff + 10'd1 : rel_ff;
      hold_inc    = (hold_ff < gsem_pkg::HOLD_SAT) ? hold_ff + 16'd1 : hold_ff;

      case (gsem_pkg::kind_type'(item_ff.kind))
         gsem_pkg::KIND_REPORT: begin
            if (conn_ff) begin
               if (combo && !held_ff) begin
                  held_in     = 1'b1;
                  switched_in = 1'b0;
                  hold_in     = 16'd0;
               end else if (!combo) begin
                  held_in = 1'b0;
               end
               servo_in = ang_clamped;
               motor_in = mot;
            end
         end
         gsem_pkg::KIND_TICK: begin
            rel_in = rel_inc;
            if (held_ff && !switched_ff) begin
               hold_in = hold_inc;
               if (hold_inc >= hold_ms_ff) begin
                  case (mode_ff)
                     gsem_pkg::MODE_ECO: begin
                        mode_in = gsem_pkg::MODE_NORMAL;
                        rhi     = gsem_pkg::RUMBLE_HI_NORMAL;
                        rlen_in = gsem_pkg::RUMBLE_LEN_NORMAL;
                        led_in  = gsem_pkg::LED_BLUE;
                     end
                     gsem_pkg::MODE_NORMAL: begin
                        mode_in = gsem_pkg::MODE_SPORT;
                        rhi     = gsem_pkg::RUMBLE_HI_SPORT;
                        rlen_in = gsem_pkg::RUMBLE_LEN_SPORT;
                        led_in  = gsem_pkg::LED_RED;
                     end
                     default: begin
                        mode_in = gsem_pkg::MODE_ECO;
                        rlo     = gsem_pkg::RUMBLE_LO_ECO;
                        rlen_in = gsem_pkg::RUMBLE_LEN_ECO;
                        led_in  = gsem_pkg::LED_GREEN;
                     end
                  endcase
                  rv          = 1'b1;
                  started     = 1'b1;
                  ract_in     = 1'b1;
                  rel_in      = 10'd0;
                  switched_in = 1'b1;
               end
            end
            // timed-out rumble issues a stop command
            if (!started && ract_ff && rel_inc >= rlen_ff) begin
               rv      = 1'b1;
               ract_in = 1'b0;
            end
         end
         gsem_pkg::KIND_CONNECT: begin
            led_in  = gsem_pkg::LED_GREEN;
            conn_in = 1'b1;
         end
         default: begin
            led_in   = gsem_pkg::LED_OFF;
            held_in  = 1'b0;
            ract_in  = 1'b0;
            conn_in  = 1'b0;
            servo_in = acen_ff;
            motor_in = gsem_pkg::NEUTRAL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= gsem_pkg::MODE_ECO;
         servo_ff    <= gsem_pkg::ANGLE_CENTER_RST;
         motor_ff    <= gsem_pkg::NEUTRAL;
         conn_ff     <= 1'b0;
         held_ff     <= 1'b0;
         switched_ff <= 1'b0;
         hold_ff     <= 16'd0;
         ract_ff     <= 1'b0;
         rel_ff      <= 10'd0;
         rlen_ff     <= 10'd0;
         led_ff      <= gsem_pkg::LED_OFF;
      end else if (cmd.commit) begin
         mode_ff     <= mode_in;
         servo_ff    <= servo_in;
         motor_ff    <= motor_in;
         conn_ff     <= conn_in;
         held_ff     <= held_in;
         switched_ff <= switched_in;
         hold_ff     <= hold_in;
         ract_ff     <= ract_in;
         rel_ff      <= rel_in;
         rlen_ff     <= rlen_in;
         led_ff      <= led_in;
      end
   end

   // result register
   gsem_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.servo_angle       <= servo_in;
         rsp_ff.motor_pwm         <= motor_in;
         rsp_ff.drive_mode        <= mode_in;
         rsp_ff.pad_connected     <= conn_in;
         rsp_ff.rumble_valid      <= rv;
         rsp_ff.rumble_low_motor  <= rlo;
         rsp_ff.rumble_high_motor <= rhi;
         rsp_ff.led_color         <= led_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: design/gamepad_to_servo_esc_mapper.sv
// ----------------------------------------------------------------------------
// gamepad_to_servo_esc_mapper: gamepad events to servo, ESC, mode and rumble
// Controller sequences one event at a time through the datapath.
//
//   channel | ports                           | role
//   --------+---------------------------------+-----------------------------
//   req     | req_valid req_stall req_data    | event in (report/tick/conn)
//   rsp     | rsp_valid rsp_stall rsp_data    | one result per event
//   csr     | csr_we csr_index csr_wdata      | register write, no wait
//
// The result is registered after the multiply state, a 23-step restoring
// divider for the stick slope and the commit state. The next input transfer
// is taken in idle after the commit, so a new event is not taken before the
// last one is committed.
// The result register frees the input side: a new event is accepted while a
// result still waits; the commit only waits if that result is still stalled.
// Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module gamepad_to_servo_esc_mapper (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gsem_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gsem_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [gsem_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gsem_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   gsem_pkg::cmd_type cmd;

   gsem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   gsem_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

   // one event in flight: a transfer is always followed by a stall
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while an event is in flight");

   // rumble strengths only accompany a rumble command
   a_rumble_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.rumble_valid) |->
      (rsp_data.rumble_low_motor == 8'd0 && rsp_data.rumble_high_motor == 8'd0))
      else $error("rumble strength without rumble command");

   // while disconnected the motor sits at neutral with the LED off
   a_disconnected_neutral: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.pad_connected) |->
      (rsp_data.motor_pwm == gsem_pkg::NEUTRAL && rsp_data.led_color == gsem_pkg::LED_OFF))
      else $error("disconnected result not at neutral");

endmodule

// File: test/tb_gamepad_to_servo_esc_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gamepad_to_servo_esc_mapper: self-checking bench for the gamepad mapper
// A queue-fed driver sends events, and a behavioral copy of the mapper
// predicts the result of each accepted one. The monitor compares every result
// field by field. The run starts with directed corner events, then random
// connect/disconnect/report/combo/tick sequences over several register settings
// and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_gamepad_to_servo_esc_mapper;
   import gsem_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 40;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_plan_type;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   gamepad_to_servo_esc_mapper i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register shadow
   logic [7:0]  cfg_angle_min;
   logic [7:0]  cfg_angle_max;
   logic [7:0]  cfg_angle_center;
   logic [14:0] cfg_dead_zone;
   logic [15:0] cfg_hold_ms;
   logic        cfg_motor_inv;

   // mapper state
   mode_type    mode_q;
   logic [7:0]  servo_q;
   logic [7:0]  motor_q;
   logic        pad_q;
   logic        combo_q;
   logic        switched_q;
   logic [15:0] hold_cnt;
   logic        rumble_on;
   logic [9:0]  rumble_cnt;
   logic [9:0]  rumble_len;
   led_type     led_q;

   req_type     pending_events[$];
   rsp_type     predicted_outputs[$];
   int unsigned accept_count   = 0;
   int unsigned done_count     = 0;
   int unsigned cycle_count    = 0;
   int          fail_count     = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   logic        drain_pause    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int scale_side(int x, int in_lo, int in_hi, int out_lo, int out_hi);
      return (x - in_lo) * (out_hi - out_lo) / (in_hi - in_lo) + out_lo;
   endfunction

   function automatic int gas_endpoint(mode_type m);
      int e;
      case (m)
         MODE_NORMAL: e = 150;
         MODE_SPORT:  e = 180;
         default:     e = 120;
      endcase
      return e;
   endfunction

   function automatic int brake_endpoint(mode_type m);
      int e;
      case (m)
         MODE_NORMAL: e = 30;
         MODE_SPORT:  e = 0;
         default:     e = 60;
      endcase
      return e;
   endfunction

   task automatic reset_mapper_state();
      mode_q     = MODE_ECO;
      servo_q    = ANGLE_CENTER_RST;
      motor_q    = NEUTRAL;
      pad_q      = 1'b0;
      combo_q    = 1'b0;
      switched_q = 1'b0;
      hold_cnt   = '0;
      rumble_on  = 1'b0;
      rumble_cnt = '0;
      rumble_len = '0;
      led_q      = LED_OFF;
   endtask

   task automatic map_event(input req_type ev, output rsp_type res);
      int x, dz, ang, amin, amax, actr, thr, brk, mot, gas_e, brake_e;
      logic both, started, rv;
      logic [7:0] rlo, rhi;
      started = 1'b0;
      rv      = 1'b0;
      rlo     = '0;
      rhi     = '0;
      case (ev.kind)
         KIND_REPORT: begin
            if (pad_q) begin
               x    = int'(ev.stick_x);
               dz   = int'(cfg_dead_zone);
               amin = int'(cfg_angle_min);
               amax = int'(cfg_angle_max);
               actr = int'(cfg_angle_center);
               ang  = actr;
               if (x > dz)
                  ang = scale_side(x, dz, 32767, actr, amax);
               else if (x < -dz)
                  ang = scale_side(x, -dz, -32768, actr, amin);
               // min clamp checked first: when the clamps cross, an angle below amin takes amin, any other takes amax
               if (ang < amin)
                  ang = amin;
               else if (ang > amax)
                  ang = amax;

               both = ev.left_shoulder && ev.right_shoulder;
               if (both && !combo_q) begin
                  combo_q    = 1'b1;
                  switched_q = 1'b0;
                  hold_cnt   = '0;
               end else if (!both) begin
                  combo_q = 1'b0;
               end

               gas_e   = gas_endpoint(mode_q);
               brake_e = brake_endpoint(mode_q);
               thr     = int'(ev.throttle_trigger);
               brk     = int'(ev.brake_trigger);
               mot     = int'(NEUTRAL);
               if (thr > 0)
                  mot = scale_side(thr, 0, 255, int'(NEUTRAL), cfg_motor_inv ? brake_e : gas_e);
               else if (brk > 0)
                  mot = scale_side(brk, 0, 255, int'(NEUTRAL), cfg_motor_inv ? gas_e : brake_e);
               servo_q = ang[7:0];
               motor_q = mot[7:0];
            end
         end
         KIND_TICK: begin
            if (rumble_on && rumble_cnt < RUMBLE_SAT)
               rumble_cnt = rumble_cnt + 1'b1;
            if (combo_q && !switched_q) begin
               if (hold_cnt < HOLD_SAT)
                  hold_cnt = hold_cnt + 1'b1;
               if (hold_cnt >= cfg_hold_ms) begin
                  case (mode_q)
                     MODE_ECO: begin
                        mode_q     = MODE_NORMAL;
                        rhi        = RUMBLE_HI_NORMAL;
                        rumble_len = RUMBLE_LEN_NORMAL;
                        led_q      = LED_BLUE;
                     end
                     MODE_NORMAL: begin
                        mode_q     = MODE_SPORT;
                        rhi        = RUMBLE_HI_SPORT;
                        rumble_len = RUMBLE_LEN_SPORT;
                        led_q      = LED_RED;
                     end
                     default: begin
                        mode_q     = MODE_ECO;
                        rlo        = RUMBLE_LO_ECO;
                        rumble_len = RUMBLE_LEN_ECO;
                        led_q      = LED_GREEN;
                     end
                  endcase
                  rv         = 1'b1;
                  started    = 1'b1;
                  rumble_on  = 1'b1;
                  rumble_cnt = '0;
                  switched_q = 1'b1;
               end
            end
            // rumble timed out: stop command
            if (!started && rumble_on && rumble_cnt >= rumble_len) begin
               rv        = 1'b1;
               rlo       = '0;
               rhi       = '0;
               rumble_on = 1'b0;
            end
         end
         KIND_CONNECT: begin
            led_q = LED_GREEN;
            pad_q = 1'b1;
         end
         default: begin
            led_q     = LED_OFF;
            combo_q   = 1'b0;
            rumble_on = 1'b0;
            pad_q     = 1'b0;
            servo_q   = cfg_angle_center;
            motor_q   = NEUTRAL;
         end
      endcase
      res.servo_angle       = servo_q;
      res.motor_pwm         = motor_q;
      res.drive_mode        = mode_q;
      res.pad_connected     = pad_q;
      res.rumble_valid      = rv;
      res.rumble_low_motor  = rlo;
      res.rumble_high_motor = rhi;
      res.led_color         = led_q;
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : drive_proc
      rsp_type predicted;
      logic    accepted;
      if (reset) begin
         reset_mapper_state();
         drain_pause = 1'b0;
         req_valid <= 1'b0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) begin
            map_event(req_data, predicted);
            predicted_outputs.push_back(predicted);
            accept_count <= accept_count + 1;
            // now and then hold off until everything in flight has come back
            if ($urandom_range(0, 59) == 0)
               drain_pause = 1'b1;
         end else if (drain_pause && accept_count == done_count) begin
            drain_pause = 1'b0;
         end
         if (!req_valid || accepted) begin
            if (!drain_pause && pending_events.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_events.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor_proc
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_outputs.size() == 0) begin
               $error("result transfer with no expected result");
               fail_count++;
            end else begin
               want = predicted_outputs.pop_front();
               check_field("servo_angle", int'(want.servo_angle),
                           int'(rsp_data.servo_angle));
               check_field("motor_pwm", int'(want.motor_pwm), int'(rsp_data.motor_pwm));
               check_field("drive_mode", int'(want.drive_mode), int'(rsp_data.drive_mode));
               check_field("pad_connected", int'(want.pad_connected),
                           int'(rsp_data.pad_connected));
               check_field("rumble_valid", int'(want.rumble_valid),
                           int'(rsp_data.rumble_valid));
               check_field("rumble_low_motor", int'(want.rumble_low_motor),
                           int'(rsp_data.rumble_low_motor));
               check_field("rumble_high_motor", int'(want.rumble_high_motor),
                           int'(rsp_data.rumble_high_motor));
               check_field("led_color", int'(want.led_color), int'(rsp_data.led_color));
            end
            done_count <= done_count + 1;
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic req_type make_fixed(kind_type k, logic signed [15:0] stick,
                                          logic [7:0] thr, logic [7:0] brk,
                                          logic lsh, logic rsh);
      req_type ev;
      ev.kind             = k;
      ev.stick_x          = stick;
      ev.throttle_trigger = thr;
      ev.brake_trigger    = brk;
      ev.left_shoulder    = lsh;
      ev.right_shoulder   = rsh;
      return ev;
   endfunction

   // stick values cluster on the rails and the dead-zone edges
   function automatic logic signed [15:0] pick_stick();
      int dz;
      logic signed [15:0] s;
      dz = int'(cfg_dead_zone);
      case ($urandom_range(0, 7))
         0:       s = 16'sh7fff;
         1:       s = 16'sh8000;
         2:       s = 16'(dz);
         3:       s = 16'(dz + 1);
         4:       s = 16'(-dz);
         5:       s = 16'(-dz - 1);
         default: s = 16'($urandom);
      endcase
      return s;
   endfunction

   function automatic logic [7:0] pick_trigger();
      logic [7:0] t;
      case ($urandom_range(0, 7))
         0, 1:    t = 8'd0;
         2:       t = 8'd255;
         default: t = 8'($urandom_range(0, 255));
      endcase
      return t;
   endfunction

   function automatic req_type make_event(kind_type k, logic lsh, logic rsh);
      return make_fixed(k, pick_stick(), pick_trigger(), pick_trigger(), lsh, rsh);
   endfunction

   task automatic fill_random(int budget);
      int pick, n;
      logic [1:0] sh;
      while (pending_events.size() < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            pending_events.push_back(make_event(kind_type'($urandom_range(0, 3)),
                                                1'($urandom_range(0, 1)),
                                                1'($urandom_range(0, 1))));
         end else if (pick < 13) begin
            pending_events.push_back(make_event(KIND_DISCONNECT, 1'b0, 1'b0));
            if ($urandom_range(0, 1) != 0)
               pending_events.push_back(make_event(KIND_CONNECT, 1'b0, 1'b0));
         end else if (pick < 18) begin
            pending_events.push_back(make_event(KIND_CONNECT, 1'b0, 1'b0));
         end else if (pick < 58) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               sh = 2'($urandom_range(0, 3));
               pending_events.push_back(make_event(KIND_REPORT, sh[1], sh[0]));
               if ($urandom_range(0, 9) < 3)
                  pending_events.push_back(make_event(KIND_TICK, 1'b0, 1'b0));
            end
         end else if (pick < 90) begin
            // shoulder combo: press, tick (up to hold_ms only when it is at most 6), then maybe release
            pending_events.push_back(make_event(KIND_REPORT, 1'b1, 1'b1));
            if (cfg_hold_ms <= 16'd6)
               n = int'(cfg_hold_ms) + $urandom_range(0, 2);
            else
               n = $urandom_range(1, 6);
            repeat (n) begin
               if ($urandom_range(0, 6) == 0)
                  pending_events.push_back(make_event(KIND_REPORT, 1'b1, 1'b1));
               pending_events.push_back(make_event(KIND_TICK, 1'b0, 1'b0));
            end
            if ($urandom_range(0, 4) != 0) begin
               sh = 2'($urandom_range(0, 2));
               pending_events.push_back(make_event(KIND_REPORT, sh[1], sh[0]));
            end
         end else begin
            repeat ($urandom_range(1, 10))
               pending_events.push_back(make_event(KIND_TICK, 1'b0, 1'b0));
         end
      end
   endtask

   task automatic set_idle(idle_plan_type plan);
      case (plan)
         IDLE_SENDER: begin
            send_idle_pct  = 46;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 46;
         end
         IDLE_BOTH: begin
            send_idle_pct  = 13;
            recv_stall_pct = 13;
         end
         default: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
      endcase
   endtask

   task automatic write_reg(csr_idx_type idx, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      case (idx)
         CSR_ANGLE_MIN:    cfg_angle_min    = value[7:0];
         CSR_ANGLE_MAX:    cfg_angle_max    = value[7:0];
         CSR_ANGLE_CENTER: cfg_angle_center = value[7:0];
         CSR_DEAD_ZONE:    cfg_dead_zone    = value[14:0];
         CSR_HOLD_MS:      cfg_hold_ms      = value[15:0];
         CSR_MOTOR_INV:    cfg_motor_inv    = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(int amin, int amax, int actr, int dz, int hold, int inv);
      write_reg(CSR_ANGLE_MIN, amin);
      write_reg(CSR_ANGLE_MAX, amax);
      write_reg(CSR_ANGLE_CENTER, actr);
      write_reg(CSR_DEAD_ZONE, dz);
      write_reg(CSR_HOLD_MS, hold);
      write_reg(CSR_MOTOR_INV, inv);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait for every transfer to come back, then let the block go quiet
   task automatic settle();
      while (pending_events.size() != 0 || req_valid || accept_count != done_count)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(int amin, int amax, int actr, int dz, int hold, int inv,
                             idle_plan_type plan, int budget);
      settle();
      apply_settings(amin, amax, actr, dz, hold, inv);
      set_idle(plan);
      fill_random(budget);
   endtask

   initial begin
      cfg_angle_min    = ANGLE_MIN_RST;
      cfg_angle_max    = ANGLE_MAX_RST;
      cfg_angle_center = ANGLE_CENTER_RST;
      cfg_dead_zone    = DEAD_ZONE_RST;
      cfg_hold_ms      = HOLD_MS_RST;
      cfg_motor_inv    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings: disconnected reports, connect, stick and trigger rails
      set_idle(IDLE_NONE);
      pending_events.push_back(make_fixed(KIND_REPORT, 16'sh7fff, 8'd255, 8'd0, 1'b1, 1'b1));
      pending_events.push_back(make_fixed(KIND_TICK, 16'sh0000, 8'd0, 8'd0, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_CONNECT, 16'sh0000, 8'd0, 8'd0, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_CONNECT, 16'sh8000, 8'd255, 8'd255, 1'b1, 1'b1));
      pending_events.push_back(make_fixed(KIND_REPORT, 16'sh7fff, 8'd255, 8'd0, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_REPORT, 16'sh8000, 8'd0, 8'd255, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_REPORT, 16'sh0000, 8'd0, 8'd0, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_REPORT, 16'sd4000, 8'd1, 8'd0, 1'b1, 1'b0));
      pending_events.push_back(make_fixed(KIND_REPORT, 16'sd4001, 8'd0, 8'd1, 1'b0, 1'b1));
      pending_events.push_back(make_fixed(KIND_REPORT, -16'sd4000, 8'd0, 8'd0, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_REPORT, -16'sd4001, 8'd128, 8'd200, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_DISCONNECT, 16'sh7fff, 8'd255, 8'd255, 1'b1, 1'b1));
      pending_events.push_back(make_fixed(KIND_REPORT, 16'sh7fff, 8'd255, 8'd0, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_CONNECT, 16'sh0000, 8'd0, 8'd0, 1'b0, 1'b0));

      // directed: crossed clamps, trim outside the endpoints, inverted motor,
      // zero hold time, all three mode steps, rumble replaced, rumble timed out,
      // disconnect mid-rumble
      settle();
      apply_settings(120, 60, 180, 4000, 0, 1);
      pending_events.push_back(make_fixed(KIND_CONNECT, 16'sh0000, 8'd0, 8'd0, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_REPORT, 16'sh7fff, 8'd255, 8'd0, 1'b1, 1'b1));
      pending_events.push_back(make_fixed(KIND_TICK, 16'sh0000, 8'd0, 8'd0, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_TICK, 16'sh0000, 8'd0, 8'd0, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_REPORT, 16'sh8000, 8'd0, 8'd255, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_REPORT, 16'sh0000, 8'd77, 8'd0, 1'b1, 1'b1));
      pending_events.push_back(make_fixed(KIND_TICK, 16'sh0000, 8'd0, 8'd0, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_REPORT, 16'sd9000, 8'd0, 8'd33, 1'b1, 1'b0));
      pending_events.push_back(make_fixed(KIND_REPORT, -16'sd9000, 8'd200, 8'd0, 1'b1, 1'b1));
      pending_events.push_back(make_fixed(KIND_TICK, 16'sh0000, 8'd0, 8'd0, 1'b0, 1'b0));
      // ride out the eco rumble until its stop command
      repeat (int'(RUMBLE_LEN_ECO))
         pending_events.push_back(make_fixed(KIND_TICK, 16'sh0000, 8'd0, 8'd0, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_REPORT, 16'sh0000, 8'd0, 8'd0, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_REPORT, 16'sh0000, 8'd0, 8'd0, 1'b1, 1'b1));
      pending_events.push_back(make_fixed(KIND_TICK, 16'sh0000, 8'd0, 8'd0, 1'b0, 1'b0));
      pending_events.push_back(make_fixed(KIND_DISCONNECT, 16'sh0000, 8'd0, 8'd0, 1'b0, 1'b0));

      run_random(45, 115, 85, 4000, 3, 0, IDLE_NONE, 95);
      run_random(0, 180, 90, 0, 0, 1, IDLE_SENDER, 95);
      run_random(150, 30, 180, 32766, 65535, 0, IDLE_RECEIVER, 95);
      run_random(20, 160, 0, $urandom_range(0, 32766), 1, 1, IDLE_BOTH, 95);
      run_random($urandom_range(0, 180), $urandom_range(0, 180), $urandom_range(0, 180),
                 $urandom_range(0, 32766), $urandom_range(0, 4), $urandom_range(0, 1),
                 IDLE_NONE, 95);
      run_random(180, 0, 0, 12000, 2, 0, IDLE_SENDER, 95);
      run_random($urandom_range(0, 180), $urandom_range(0, 180), $urandom_range(0, 180),
                 $urandom_range(0, 32766), $urandom_range(0, 4), $urandom_range(0, 1),
                 IDLE_BOTH, 95);
      settle();

      if (fail_count == 0 && predicted_outputs.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (predicted_outputs.size() != 0)
            $error("%0d expected results never arrived", predicted_outputs.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
design/gsem_pkg.sv
design/gsem_ctrl.sv
design/gsem_datapath.sv
design/gamepad_to_servo_esc_mapper.sv
test/tb_gamepad_to_servo_esc_mapper.sv
